// File: rtl/lkv_pkg.sv
// Shared types, sizes and a helper function for the LRU key-value cache.
`timescale 1ns / 1ps
package lkv_pkg;

  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 16;
  localparam int VAL_W    = 32;
  localparam int CAP_W    = 5;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int RANK_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ADDR_W   = 2;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
  localparam logic [ADDR_W-1:0] REG_CAPACITY = 2'd0;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                hit;
    logic [VAL_W-1:0]    read_value;
    logic                evicted;
    logic [KEY_BITS-1:0] evicted_key;
  } result_t;

  // Capacity as used by the replacement logic: zero acts as one, large values saturate.
  function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
    logic [CNT_W-1:0] c;
    if (cap == '0) begin
      c = CNT_W'(1);
    end else if (int'(cap) > ENTRIES) begin
      c = CNT_W'(ENTRIES);
    end else begin
      c = CNT_W'(cap);
    end
    return c;
  endfunction

endpackage

// File: rtl/lru_key_value_cache.sv
// Fully associative LRU key-value cache: input stage, entry store, result stage.
// A result strobes on done once the item has passed the input and result registers.
// Throughput: one item per cycle; busy stays low since each item's lookup
// and update finish between the input and result registers.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset empties the cache and sets capacity to 16.
`timescale 1ns / 1ps
module lru_key_value_cache (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation,
  input  logic [lkv_pkg::KEY_BITS-1:0] key,
  input  logic signed [31:0]           write_value,
  output logic                         done,
  output logic                         hit,
  output logic signed [31:0]           read_value,
  output logic                         evicted,
  output logic [lkv_pkg::KEY_BITS-1:0] evicted_key,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lkv_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import lkv_pkg::*;

  logic                in_valid;
  logic                in_op;
  logic [KEY_BITS-1:0] in_key;
  logic [VAL_W-1:0]    in_wval;
  logic [CAP_W-1:0]    capacity;
  result_t             result;

  assign busy = 1'b0;

  lkv_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_op   <= operation;
      in_key  <= key;
      in_wval <= write_value;
    end
  end

  lkv_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_key   (in_key),
    .in_wval  (in_wval),
    .capacity (capacity),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      hit         <= result.hit;
      read_value  <= result.read_value;
      evicted     <= result.evicted;
      evicted_key <= result.evicted_key;
    end
  end

  // An accepted item always produces its result on done after the input and result registers.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted item produced no result");

  // An eviction only happens on a miss.
  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> !hit)
    else $error("eviction reported on a hit");

  // Without an eviction the reported key is zero.
  a_evkey_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !evicted) |-> (evicted_key == '0))
    else $error("evicted key set without eviction");

  // A miss always reads back all ones.
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (read_value == -32'sd1))
    else $error("miss returned a stored value");

endmodule

// File: rtl/lkv_cfg.sv
// APB register block holding the capacity register.
`timescale 1ns / 1ps
module lkv_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lkv_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [lkv_pkg::CAP_W-1:0] capacity
);
  import lkv_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (wr_en && paddr == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr)
      REG_CAPACITY: prdata = {{(32-CAP_W){1'b0}}, capacity};
      default:      prdata = '0;
    endcase
  end

endmodule

// File: rtl/lkv_core.sv
// Entry store with parallel key match, recency ranks and LRU replacement.
`timescale 1ns / 1ps
module lkv_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_op,
  input  logic [lkv_pkg::KEY_BITS-1:0] in_key,
  input  logic [lkv_pkg::VAL_W-1:0]    in_wval,
  input  logic [lkv_pkg::CAP_W-1:0]    capacity,
  output lkv_pkg::result_t             result
);
  import lkv_pkg::*;

  logic [ENTRIES-1:0]  entry_valid;
  logic [KEY_BITS-1:0] entry_key   [ENTRIES];
  logic [VAL_W-1:0]    entry_value [ENTRIES];
  logic [RANK_W-1:0]   recency_rank[ENTRIES];
  logic [CNT_W-1:0]    occupancy;

  logic [ENTRIES-1:0]  match;
  logic [ENTRIES-1:0]  victim;
  logic [ENTRIES-1:0]  free_oh;
  logic [ENTRIES-1:0]  ins_oh;
  logic                hit;
  logic                is_put;
  logic                do_evict;
  logic                do_insert;
  logic [VAL_W-1:0]    sel_value;
  logic [RANK_W-1:0]   sel_rank;
  logic [KEY_BITS-1:0] victim_key;
  logic [CNT_W-1:0]    occ_m1;

  assign is_put = (in_op == OP_PUT);
  assign occ_m1 = occupancy - CNT_W'(1);

  // Valid keys are unique, so at most one entry matches; the least recent
  // entry is the one whose rank equals occupancy minus one.
  always_comb begin
    sel_value  = '0;
    sel_rank   = '0;
    victim_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = entry_valid[i] && (entry_key[i] == in_key);
      victim[i] = entry_valid[i] && (recency_rank[i] == occ_m1[RANK_W-1:0]);
      if (match[i]) begin
        sel_value = sel_value | entry_value[i];
        sel_rank  = sel_rank | recency_rank[i];
      end
      if (victim[i]) begin
        victim_key = victim_key | entry_key[i];
      end
    end
  end

  assign hit       = |match;
  assign do_evict  = is_put && !hit && (occupancy != '0) &&
                     (occupancy >= eff_capacity(capacity));
  assign do_insert = is_put && !hit;
  assign free_oh   = ~entry_valid & (entry_valid + ENTRIES'(1));
  assign ins_oh    = do_evict ? victim : free_oh;

  always_comb begin
    result.hit         = hit;
    result.read_value  = hit ? sel_value : '1;
    result.evicted     = do_evict;
    result.evicted_key = do_evict ? victim_key : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
    end else if (in_valid && do_insert) begin
      entry_valid <= entry_valid | ins_oh;
      if (!do_evict) begin
        occupancy <= occupancy + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit) begin
          if (match[i]) begin
            recency_rank[i] <= '0;
            if (is_put) begin
              entry_value[i] <= in_wval;
            end
          end else if (entry_valid[i] && recency_rank[i] < sel_rank) begin
            recency_rank[i] <= recency_rank[i] + RANK_W'(1);
          end
        end else if (do_insert) begin
          if (ins_oh[i]) begin
            entry_key[i]    <= in_key;
            entry_value[i]  <= in_wval;
            recency_rank[i] <= '0;
          end else if (entry_valid[i]) begin
            recency_rank[i] <= recency_rank[i] + RANK_W'(1);
          end
        end
      end
    end
  end

endmodule

// File: dv/tb_lru_key_value_cache.sv
// Self-checking testbench for the LRU key-value cache with an APB capacity register.
`timescale 1ns / 1ps
module tb_lru_key_value_cache;
  import lkv_pkg::*;

  typedef enum logic [1:0] {STIM_ITEM, STIM_CFG, STIM_IDLE, STIM_DRAIN} stim_kind_t;

  typedef struct {
    stim_kind_t          kind;
    logic                op;
    logic [KEY_BITS-1:0] key;
    logic [VAL_W-1:0]    value;
    logic [31:0]         cfg_data;
    int unsigned         cycles;
  } stim_t;

  localparam int unsigned SETTLE_CYCLES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic operation = OP_GET;
  logic [KEY_BITS-1:0] key = '0;
  logic signed [31:0] write_value = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = REG_CAPACITY;
  logic [31:0] pwdata = '0;
  wire busy;
  wire done;
  wire hit;
  wire signed [31:0] read_value;
  wire evicted;
  wire [KEY_BITS-1:0] evicted_key;
  wire [31:0] prdata;
  wire pready;

  lru_key_value_cache DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .key(key), .write_value(write_value),
    .done(done), .hit(hit), .read_value(read_value), .evicted(evicted),
    .evicted_key(evicted_key),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the cache contents, kept in step with accepted items.
  logic                slot_valid [ENTRIES];
  logic [KEY_BITS-1:0] slot_key   [ENTRIES];
  logic [VAL_W-1:0]    slot_value [ENTRIES];
  int unsigned         slot_age   [ENTRIES];
  int unsigned         slots_used;
  logic [CAP_W-1:0]    shadow_capacity;

  stim_t       stim_plan[$];
  result_t     expected_results[$];
  int unsigned error_count = 0;
  logic        item_taken = 1'b0;
  logic        draining = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned phase_gaps = 0;

  function automatic int unsigned capacity_limit();
    if (shadow_capacity == '0) return 1;
    if (int'(shadow_capacity) > ENTRIES) return ENTRIES;
    return int'(shadow_capacity);
  endfunction

  // Applies one get or put to the shadow cache and returns the result it yields.
  function automatic result_t cache_access(logic op, logic [KEY_BITS-1:0] k,
                                           logic [VAL_W-1:0] v);
    result_t     r;
    int          found;
    int          victim;
    int          free_slot;
    int unsigned age;
    r.hit = 1'b0;
    r.read_value = '1;
    r.evicted = 1'b0;
    r.evicted_key = '0;
    found = -1;
    victim = -1;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_key[i] == k && found < 0) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      r.read_value = slot_value[found];
      if (op == OP_PUT) slot_value[found] = v;
      age = slot_age[found];
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && slot_age[i] < age) slot_age[i]++;
      end
      slot_age[found] = 0;
    end else if (op == OP_PUT) begin
      if (slots_used >= capacity_limit() && slots_used > 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
        end
        if (victim >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[victim];
          slot_valid[victim] = 1'b0;
          slots_used--;
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (!slot_valid[i] && free_slot < 0) free_slot = i;
      end
      if (free_slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i]) slot_age[i]++;
        end
        slot_valid[free_slot] = 1'b1;
        slot_key[free_slot] = k;
        slot_value[free_slot] = v;
        slot_age[free_slot] = 0;
        slots_used++;
      end
    end
    return r;
  endfunction

  // Driver: works through the plan one step per falling edge.
  always @(negedge clk) begin
    stim_t act;
    logic  n_start;
    logic  n_psel;
    logic  n_penable;
    n_start = 1'b0;
    n_psel = 1'b0;
    n_penable = 1'b0;
    if (!rst) begin
      if (start && !item_taken) begin
        n_start = 1'b1;
      end else if (psel && !penable) begin
        n_psel = 1'b1;
        n_penable = 1'b1;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
      end else if (draining) begin
        // Wait until every expected result has arrived, then allow a settling margin.
        if (expected_results.size() == 0) begin
          draining = 1'b0;
          hold_cycles = SETTLE_CYCLES;
        end
      end else if (stim_plan.size() > 0) begin
        act = stim_plan.pop_front();
        case (act.kind)
          STIM_ITEM: begin
            n_start = 1'b1;
            operation <= act.op;
            key <= act.key;
            write_value <= act.value;
          end
          STIM_CFG: begin
            n_psel = 1'b1;
            pwrite <= 1'b1;
            paddr <= REG_CAPACITY;
            pwdata <= act.cfg_data;
          end
          STIM_IDLE: begin
            hold_cycles = act.cycles;
          end
          STIM_DRAIN: begin
            draining = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
    start <= n_start;
    psel <= n_psel;
    penable <= n_penable;
  end

  // Monitor: checks results, tracks register writes and predicts accepted items.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i] = '0;
        slot_value[i] = '0;
        slot_age[i] = 0;
      end
      slots_used = 0;
      shadow_capacity = CAP_RESET;
      item_taken <= 1'b0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no item outstanding");
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (hit !== exp_r.hit) begin
            $error("hit: expected %0b, got %0b", exp_r.hit, hit);
            error_count++;
          end
          if (read_value !== exp_r.read_value) begin
            $error("read_value: expected %0d, got %0d", $signed(exp_r.read_value),
                   read_value);
            error_count++;
          end
          if (evicted !== exp_r.evicted) begin
            $error("evicted: expected %0b, got %0b", exp_r.evicted, evicted);
            error_count++;
          end
          if (evicted_key !== exp_r.evicted_key) begin
            $error("evicted_key: expected 0x%04h, got 0x%04h", exp_r.evicted_key,
                   evicted_key);
            error_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == REG_CAPACITY) begin
        shadow_capacity = pwdata[CAP_W-1:0];
      end
      if (start && !busy) begin
        exp_r = cache_access(operation, key, write_value);
        expected_results.insert(expected_results.size(), exp_r);
      end
      item_taken <= start && !busy;
    end
  end

  function automatic int unsigned random_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic plan_item(logic op, logic [KEY_BITS-1:0] k, logic [VAL_W-1:0] v);
    stim_t s;
    int unsigned gap;
    gap = (phase_gaps != 0) ? random_gap() : 0;
    if (gap > 0) begin
      s.kind = STIM_IDLE;
      s.cycles = gap;
      stim_plan.insert(stim_plan.size(), s);
    end
    s.kind = STIM_ITEM;
    s.op = op;
    s.key = k;
    s.value = v;
    stim_plan.insert(stim_plan.size(), s);
  endtask

  task automatic plan_drain();
    stim_t s;
    s.kind = STIM_DRAIN;
    stim_plan.insert(stim_plan.size(), s);
  endtask

  // The upper data bits are don't-care; they are randomized to show that.
  task automatic plan_capacity(logic [CAP_W-1:0] cap);
    stim_t s;
    plan_drain();
    s.kind = STIM_CFG;
    s.cfg_data = {(32 - CAP_W)'($urandom()), cap};
    stim_plan.insert(stim_plan.size(), s);
  endtask

  task automatic plan_random_phase(logic [CAP_W-1:0] cap, int unsigned count,
                                   logic with_pause);
    logic [KEY_BITS-1:0] key_pool[$];
    int unsigned limit;
    int unsigned pool_size;
    logic [KEY_BITS-1:0] k;
    plan_capacity(cap);
    limit = (cap == '0) ? 1 : ((int'(cap) > ENTRIES) ? ENTRIES : int'(cap));
    pool_size = limit + $urandom_range(1, 6);
    key_pool.insert(key_pool.size(), KEY_BITS'(0));
    key_pool.insert(key_pool.size(), {KEY_BITS{1'b1}});
    while (key_pool.size() < pool_size) begin
      key_pool.insert(key_pool.size(), KEY_BITS'($urandom()));
    end
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) k = KEY_BITS'($urandom());
      else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      plan_item($urandom_range(0, 1) ? OP_PUT : OP_GET, k, $urandom());
      if (with_pause && n == count / 2) plan_drain();
    end
  endtask

  initial begin
    logic [CAP_W-1:0] cap;
    // Directed: field extremes, hits and misses, overwrite, eviction, odd capacities.
    phase_gaps = 1;
    plan_item(OP_GET, 16'h0000, 32'h0000_0000);
    plan_item(OP_PUT, 16'h0000, 32'h8000_0000);
    plan_item(OP_PUT, 16'hFFFF, 32'h7FFF_FFFF);
    plan_item(OP_GET, 16'h0000, 32'h0000_0000);
    plan_item(OP_GET, 16'hFFFF, 32'h0000_0000);
    plan_item(OP_PUT, 16'hFFFF, 32'hFFFF_FFFF);
    plan_item(OP_GET, 16'hFFFF, 32'h0000_0000);
    plan_item(OP_GET, 16'h1234, 32'h0000_0000);
    plan_item(OP_GET, 16'h0000, 32'hDEAD_BEEF);
    plan_capacity(5'd2);
    plan_item(OP_PUT, 16'h5555, 32'h0000_0001);
    plan_item(OP_PUT, 16'hAAAA, 32'h0000_0002);
    plan_item(OP_GET, 16'h0000, 32'h0000_0000);
    // Zero capacity behaves as one; the extra entry is kept and recycled.
    plan_capacity(5'd0);
    plan_item(OP_PUT, 16'h0F0F, 32'h1234_5678);
    plan_item(OP_PUT, 16'hF0F0, 32'h8765_4321);
    plan_item(OP_GET, 16'h0F0F, 32'h0000_0000);
    plan_item(OP_GET, 16'hF0F0, 32'h0000_0000);
    plan_capacity(5'd31);
    plan_item(OP_PUT, 16'h0001, 32'h0000_0000);
    plan_item(OP_GET, 16'h0001, 32'h0000_0000);
    plan_item(OP_PUT, 16'h8000, 32'hFFFF_FFFF);

    // Random phases alternate between back-to-back items and items with gaps.
    for (int p = 0; p < 12; p++) begin
      phase_gaps = p % 2;
      case (p)
        0: cap = 5'd16;
        1: cap = 5'd1;
        2: cap = 5'd31;
        3: cap = 5'd3;
        4: cap = 5'd0;
        5: cap = 5'd16;
        6: cap = 5'd17;
        default: cap = CAP_W'($urandom_range(2, 15));
      endcase
      plan_random_phase(cap, 150, p == 5 || p == 9);
    end

    wait (!rst);
    @(posedge clk);
    while (stim_plan.size() > 0 || start || psel || draining || hold_cycles > 0 ||
           expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
rtl/lkv_pkg.sv
rtl/lkv_cfg.sv
rtl/lkv_core.sv
rtl/lru_key_value_cache.sv
dv/tb_lru_key_value_cache.sv
